// ===== design/bpa_pkg.sv =====
// Package with constants, types and helpers for the buddy page allocator.
package bpa_pkg;

   localparam int MaxPages   = 8192;
   localparam int MaxOrder   = 10;
   localparam int NumLists   = MaxOrder + 2;
   localparam int SingleList = MaxOrder + 1;
   localparam int PageW      = 14;
   localparam int IdxW       = 13;
   localparam int ListW      = 4;
   localparam int TopBlock   = 1 << MaxOrder;

   localparam logic [PageW-1:0] NilPage = PageW'(MaxPages);

   typedef logic [PageW-1:0] page_type;
   typedef logic [ListW-1:0] list_type;

   typedef enum logic [1:0] {
      CMD_INIT      = 2'd0,
      CMD_ALLOC     = 2'd1,
      CMD_ALLOC_ONE = 2'd2,
      CMD_FREE      = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_BASE  = 1'b0,
      CSR_TOTAL = 1'b1
   } csr_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INIT_CLR,
      ST_INIT_PUSH,
      ST_INIT_TOP,
      ST_INIT_SINGLE,
      ST_POP_LINK,
      ST_POP_DONE,
      ST_SPLIT,
      ST_MERGE_START,
      ST_MERGE_RD,
      ST_MERGE_CHK,
      ST_MERGE_PUSH,
      ST_RESULT
   } state_type;

   // True when the page is a real store entry.
   function automatic logic page_valid(input page_type p);
      return p < NilPage;
   endfunction

endpackage

// ===== design/bpa_link_ram.sv =====
// Link memory: one next-page pointer per page, registered read port.
module bpa_link_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [bpa_pkg::IdxW-1:0]   wr_addr,
   input  bpa_pkg::page_type          wr_data,
   input  logic [bpa_pkg::IdxW-1:0]   rd_addr,
   output bpa_pkg::page_type          rd_data
);

   bpa_pkg::page_type mem [bpa_pkg::MaxPages];
   bpa_pkg::page_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/buddy_page_allocator_core.sv =====
// Top level of the buddy page allocator: command sequencer around the link memory.
// An alloc pops the lowest fitting list head and splits it down to the requested order, and
// alloc-one takes from the single-page buffer first; a free into the buffer or out of range
// goes straight to the result, a merging free walks each list for the buddy and merges up.
// One item is in work at a time; the next is taken once the result has been accepted.
// Reset empties all list heads and clears control state; link memory entries are
// undefined until a push writes them and are never read before that.
module buddy_page_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fields from bit 0: cmd[1:0], pages[13:2], free_address[45:14], free_order[49:46]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fields from bit 0: ok[0], block_address[32:1], block_order[36:33]
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int PW = bpa_pkg::PageW;
   localparam int IW = bpa_pkg::IdxW;

   logic [31:0] base_ff;
   logic [13:0] total_ff;

   bpa_pkg::state_type state_ff, state_in;
   bpa_pkg::page_type  heads_ff [bpa_pkg::NumLists];
   bpa_pkg::page_type  single_start_ff, single_start_in;

   bpa_pkg::cmd_type   cmd_ff, cmd_in;
   logic [11:0]        count_ff, count_in;
   logic [31:0]        addr_ff, addr_in;
   logic [3:0]         ford_ff, ford_in;

   bpa_pkg::list_type  ord_ff, ord_in;    // order being popped or merged
   bpa_pkg::list_type  rord_ff, rord_in;  // requested order
   bpa_pkg::page_type  page_ff, page_in;
   bpa_pkg::page_type  cur_ff, cur_in;
   bpa_pkg::page_type  prev_ff, prev_in;
   bpa_pkg::page_type  buddy_ff, buddy_in;
   logic [PW-1:0]      steps_ff, steps_in;
   logic               single_ff, single_in; // popping the single buffer

   logic               rsp_valid_ff, rsp_valid_in;
   logic               ok_ff, ok_in;
   logic [31:0]        baddr_ff, baddr_in;
   logic [3:0]         bord_ff, bord_in;

   logic               hd_we;
   bpa_pkg::list_type  hd_idx;
   bpa_pkg::page_type  hd_val;
   logic               clr_heads;

   logic               wr_en;
   logic [IW-1:0]      wr_addr, rd_addr;
   bpa_pkg::page_type  wr_data, rd_data;

   logic [13:0]        limit;
   logic [31:0]        diff;
   logic [19:0]        fpage;
   logic [PW-1:0]      vbit;

   bpa_link_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == bpa_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b0, bord_ff, baddr_ff, ok_ff};

   always_comb begin
      limit = total_ff;
      if (total_ff < 14'(2 * bpa_pkg::TopBlock)) limit = 14'(2 * bpa_pkg::TopBlock);
      if (total_ff > 14'(bpa_pkg::MaxPages))      limit = 14'(bpa_pkg::MaxPages);
   end

   always_comb begin
      diff  = addr_ff - base_ff;
      fpage = diff[31:12];
      vbit  = PW'(1) << ord_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         total_ff <= 14'(bpa_pkg::MaxPages);
      end else if (csr_valid && csr_ready) begin
         unique case (bpa_pkg::csr_type'(csr_index))
            bpa_pkg::CSR_BASE:  base_ff  <= csr_data;
            bpa_pkg::CSR_TOTAL: total_ff <= csr_data[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= bpa_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         single_start_ff <= '0;
         for (int i = 0; i < bpa_pkg::NumLists; i++) heads_ff[i] <= bpa_pkg::NilPage;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         single_start_ff <= single_start_in;
         if (clr_heads) begin
            for (int i = 0; i < bpa_pkg::NumLists; i++) heads_ff[i] <= bpa_pkg::NilPage;
         end else if (hd_we) begin
            heads_ff[hd_idx] <= hd_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      count_ff <= count_in;
      addr_ff  <= addr_in;
      ford_ff  <= ford_in;
      ord_ff   <= ord_in;
      rord_ff  <= rord_in;
      page_ff  <= page_in;
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      buddy_ff <= buddy_in;
      steps_ff <= steps_in;
      single_ff <= single_in;
      ok_ff    <= ok_in;
      baddr_ff <= baddr_in;
      bord_ff  <= bord_in;
   end

   always_comb begin
      state_in        = state_ff;
      single_start_in = single_start_ff;
      cmd_in   = cmd_ff;
      count_in = count_ff;
      addr_in  = addr_ff;
      ford_in  = ford_ff;
      ord_in   = ord_ff;
      rord_in  = rord_ff;
      page_in  = page_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      buddy_in = buddy_ff;
      steps_in = steps_ff;
      single_in = single_ff;
      ok_in    = ok_ff;
      baddr_in = baddr_ff;
      bord_in  = bord_ff;
      rsp_valid_in = rsp_valid_ff;
      hd_we     = 1'b0;
      hd_idx    = '0;
      hd_val    = '0;
      clr_heads = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         bpa_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in   = bpa_pkg::cmd_type'(req_tdata[1:0]);
               count_in = req_tdata[13:2];
               addr_in  = req_tdata[45:14];
               ford_in  = req_tdata[49:46];
               state_in = bpa_pkg::ST_DECODE;
            end
         end

         bpa_pkg::ST_DECODE: begin
            ok_in    = 1'b0;
            baddr_in = '0;
            bord_in  = '0;
            single_in = 1'b0;
            unique case (cmd_ff) inside
               bpa_pkg::CMD_INIT: begin
                  clr_heads = 1'b1;
                  ord_in    = '0;
                  page_in   = '0;
                  state_in  = bpa_pkg::ST_INIT_PUSH;
               end
               bpa_pkg::CMD_ALLOC, bpa_pkg::CMD_ALLOC_ONE: begin
                  if (cmd_ff == bpa_pkg::CMD_ALLOC_ONE &&
                      bpa_pkg::page_valid(heads_ff[bpa_pkg::SingleList])) begin
                     single_in = 1'b1;
                     page_in   = heads_ff[bpa_pkg::SingleList];
                     rd_addr   = heads_ff[bpa_pkg::SingleList][IW-1:0];
                     state_in  = bpa_pkg::ST_POP_LINK;
                  end else begin
                     logic [11:0] c;
                     logic [3:0]  r;
                     c = (cmd_ff == bpa_pkg::CMD_ALLOC) ? count_ff : 12'd1;
                     r = '0;
                     for (int k = 1; k <= bpa_pkg::MaxOrder; k++) begin
                        if ((12'(1) << (k - 1)) < c) r = 4'(k);
                     end
                     if (c == 12'd0 || c > 12'(bpa_pkg::TopBlock)) begin
                        state_in = bpa_pkg::ST_RESULT;
                     end else begin
                        rord_in  = r;
                        ord_in   = r;
                        state_in = bpa_pkg::ST_POP_DONE;
                        // find lowest non-empty order >= r
                        begin
                           logic found;
                           found = 1'b0;
                           for (int k = bpa_pkg::MaxOrder; k >= 0; k--) begin
                              if (4'(k) >= r && bpa_pkg::page_valid(heads_ff[k])) begin
                                 ord_in = 4'(k);
                                 found  = 1'b1;
                              end
                           end
                           if (!found) state_in = bpa_pkg::ST_RESULT;
                           else state_in = bpa_pkg::ST_POP_LINK;
                           page_in = heads_ff[ord_in];
                           rd_addr = heads_ff[ord_in][IW-1:0];
                        end
                     end
                  end
               end
               default: begin
                  if (fpage < 20'(limit)) begin
                     ok_in   = 1'b1;
                     page_in = PW'(fpage);
                     if (PW'(fpage) >= single_start_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = fpage[IW-1:0];
                        wr_data = heads_ff[bpa_pkg::SingleList];
                        hd_we   = 1'b1;
                        hd_idx  = 4'(bpa_pkg::SingleList);
                        hd_val  = PW'(fpage);
                        state_in = bpa_pkg::ST_RESULT;
                     end else begin
                        ord_in   = (ford_ff > 4'(bpa_pkg::MaxOrder)) ?
                                   4'(bpa_pkg::MaxOrder) : ford_ff;
                        state_in = bpa_pkg::ST_MERGE_START;
                     end
                  end else begin
                     state_in = bpa_pkg::ST_RESULT;
                  end
               end
            endcase
         end

         // Pages 0 and 1 to order 0, then 2^k to order k.
         bpa_pkg::ST_INIT_PUSH: begin
            logic [PW-1:0] p;
            p = (ord_ff == 4'd0) ? page_ff : (PW'(1) << ord_ff);
            wr_en   = 1'b1;
            wr_addr = p[IW-1:0];
            wr_data = heads_ff[ord_ff];
            hd_we   = 1'b1;
            hd_idx  = ord_ff;
            hd_val  = p;
            if (ord_ff == 4'd0 && page_ff == '0) begin
               page_in = PW'(1);
            end else if (ord_ff == 4'(bpa_pkg::MaxOrder)) begin
               page_in  = PW'(2 * bpa_pkg::TopBlock);
               state_in = bpa_pkg::ST_INIT_TOP;
            end else begin
               ord_in = ord_ff + 4'd1;
            end
         end

         bpa_pkg::ST_INIT_TOP: begin
            if (15'(page_ff) + 15'(bpa_pkg::TopBlock) < 15'(limit)) begin
               wr_en   = 1'b1;
               wr_addr = page_ff[IW-1:0];
               wr_data = heads_ff[bpa_pkg::MaxOrder];
               hd_we   = 1'b1;
               hd_idx  = 4'(bpa_pkg::MaxOrder);
               hd_val  = page_ff;
               page_in = page_ff + PW'(bpa_pkg::TopBlock);
            end else begin
               single_start_in = page_ff;
               state_in = bpa_pkg::ST_INIT_SINGLE;
            end
         end

         bpa_pkg::ST_INIT_SINGLE: begin
            if (page_ff < PW'(limit)) begin
               wr_en   = 1'b1;
               wr_addr = page_ff[IW-1:0];
               wr_data = heads_ff[bpa_pkg::SingleList];
               hd_we   = 1'b1;
               hd_idx  = 4'(bpa_pkg::SingleList);
               hd_val  = page_ff;
               page_in = page_ff + PW'(1);
            end else begin
               ok_in    = 1'b1;
               state_in = bpa_pkg::ST_RESULT;
            end
         end

         // Link of the popped head arrives this cycle.
         bpa_pkg::ST_POP_LINK: begin
            hd_we  = 1'b1;
            hd_idx = single_ff ? 4'(bpa_pkg::SingleList) : ord_ff;
            hd_val = rd_data;
            ok_in  = 1'b1;
            baddr_in = base_ff + {6'b0, page_ff, 12'b0};
            if (single_ff) begin
               state_in = bpa_pkg::ST_RESULT;
            end else begin
               bord_in  = rord_ff;
               state_in = bpa_pkg::ST_SPLIT;
            end
         end

         bpa_pkg::ST_POP_DONE: state_in = bpa_pkg::ST_RESULT;

         // Push upper halves one order below at each split.
         bpa_pkg::ST_SPLIT: begin
            if (ord_ff > rord_ff) begin
               logic [PW-1:0] h;
               h = page_ff + (PW'(1) << (ord_ff - 4'd1));
               if (bpa_pkg::page_valid(h)) begin
                  wr_en   = 1'b1;
                  wr_addr = h[IW-1:0];
                  wr_data = heads_ff[ord_ff - 4'd1];
                  hd_we   = 1'b1;
                  hd_idx  = ord_ff - 4'd1;
                  hd_val  = h;
               end
               ord_in = ord_ff - 4'd1;
            end else begin
               state_in = bpa_pkg::ST_RESULT;
            end
         end

         bpa_pkg::ST_MERGE_START: begin
            if (ord_ff < 4'(bpa_pkg::MaxOrder)) begin
               buddy_in = ((page_ff & ((vbit << 1) - PW'(1))) == vbit) ?
                          page_ff - vbit : page_ff + vbit;
               cur_in   = heads_ff[ord_ff];
               prev_in  = bpa_pkg::NilPage;
               steps_in = '0;
               state_in = bpa_pkg::ST_MERGE_CHK;
            end else begin
               state_in = bpa_pkg::ST_MERGE_PUSH;
            end
         end

         // End the walk at the list end or the step limit; otherwise read the current entry's link.
         bpa_pkg::ST_MERGE_CHK: begin
            if (!bpa_pkg::page_valid(cur_ff) || steps_ff == PW'(bpa_pkg::MaxPages)) begin
               state_in = bpa_pkg::ST_MERGE_PUSH;
            end else begin
               rd_addr  = cur_ff[IW-1:0];
               state_in = bpa_pkg::ST_MERGE_RD;
            end
         end

         bpa_pkg::ST_MERGE_RD: begin
            if (cur_ff == buddy_ff) begin
               if (prev_ff == bpa_pkg::NilPage) begin
                  hd_we  = 1'b1;
                  hd_idx = ord_ff;
                  hd_val = rd_data;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff[IW-1:0];
                  wr_data = rd_data;
               end
               if (buddy_ff < page_ff) page_in = buddy_ff;
               ord_in   = ord_ff + 4'd1;
               state_in = bpa_pkg::ST_MERGE_START;
            end else begin
               prev_in  = cur_ff;
               cur_in   = rd_data;
               steps_in = steps_ff + PW'(1);
               state_in = bpa_pkg::ST_MERGE_CHK;
            end
         end

         bpa_pkg::ST_MERGE_PUSH: begin
            if (bpa_pkg::page_valid(page_ff)) begin
               wr_en   = 1'b1;
               wr_addr = page_ff[IW-1:0];
               wr_data = heads_ff[ord_ff];
               hd_we   = 1'b1;
               hd_idx  = ord_ff;
               hd_val  = page_ff;
            end
            state_in = bpa_pkg::ST_RESULT;
         end

         bpa_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = bpa_pkg::ST_IDLE;
            end
         end

         default: state_in = bpa_pkg::ST_IDLE;
      endcase
   end

   // A result is raised only when leaving the result state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == bpa_pkg::ST_RESULT)
      else $error("result raised outside result state");

   // Input is never taken while a result is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready)
      else $error("input accepted with result pending");

   // A failed result reports zero address and order.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !ok_ff) |-> (baddr_ff == '0 && bord_ff == '0))
      else $error("failed result carries data");

endmodule

// ===== dv/tb_buddy_page_allocator_core.sv =====
// Self-checking testbench for the buddy page allocator core.
module tb_buddy_page_allocator_core;

   typedef struct packed {
      logic        ok;
      logic [31:0] addr;
      logic [3:0]  order;
   } alloc_rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [3:0]  order;
   } live_block_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Allocator mirror state.
   logic [13:0] link_mem[bpa_pkg::MaxPages];
   logic [13:0] heads[bpa_pkg::NumLists];
   int unsigned single_start;
   logic [31:0] base_reg;
   logic [13:0] total_reg;

   alloc_rsp_type  pending_rsp[$];
   live_block_type live_blocks[$];
   int          fails = 0;
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_count = 0;
   int          quiet_cycles = 0;

   buddy_page_allocator_core DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned managed_pages();
      int unsigned n = total_reg;
      if (n < 2 * bpa_pkg::TopBlock) n = 2 * bpa_pkg::TopBlock;
      if (n > bpa_pkg::MaxPages) n = bpa_pkg::MaxPages;
      return n;
   endfunction

   function automatic void push_block(int unsigned list, int unsigned page);
      if (page >= bpa_pkg::MaxPages) return;
      link_mem[page] = heads[list];
      heads[list] = 14'(page);
   endfunction

   function automatic int unsigned pop_head(int unsigned list);
      int unsigned h = heads[list];
      if (h >= bpa_pkg::MaxPages) return bpa_pkg::MaxPages;
      heads[list] = link_mem[h];
      return h;
   endfunction

   function automatic bit unlink_block(int unsigned list, int unsigned target);
      int unsigned prev = bpa_pkg::MaxPages;
      int unsigned cur = heads[list];
      for (int s = 0; s < bpa_pkg::MaxPages && cur < bpa_pkg::MaxPages; s++) begin
         if (cur == target) begin
            if (prev == bpa_pkg::MaxPages) heads[list] = link_mem[cur];
            else link_mem[prev] = link_mem[cur];
            return 1'b1;
         end
         prev = cur;
         cur = link_mem[cur];
      end
      return 1'b0;
   endfunction

   function automatic logic [31:0] page_addr(int unsigned page);
      return base_reg + (page << 12);
   endfunction

   function automatic alloc_rsp_type take_block(int unsigned count);
      alloc_rsp_type r = '0;
      int unsigned want = 0;
      int unsigned o;
      int unsigned p = bpa_pkg::MaxPages;
      if (count == 0 || count > bpa_pkg::TopBlock) return r;
      while ((1 << want) < count) want++;
      for (o = want; o <= bpa_pkg::MaxOrder; o++) begin
         p = pop_head(o);
         if (p != bpa_pkg::MaxPages) break;
      end
      if (p == bpa_pkg::MaxPages) return r;
      // Each split hands the upper half down one order.
      for (int unsigned k = o; k > want; k--) push_block(k - 1, p + (1 << (k - 1)));
      r.ok = 1'b1;
      r.addr = page_addr(p);
      r.order = 4'(want);
      return r;
   endfunction

   function automatic void seed_lists();
      int unsigned n = managed_pages();
      int unsigned p;
      for (int i = 0; i < bpa_pkg::NumLists; i++) heads[i] = 14'(bpa_pkg::MaxPages);
      push_block(0, 0);
      push_block(0, 1);
      for (int i = 1; i <= bpa_pkg::MaxOrder; i++) push_block(i, 1 << i);
      p = 2 * bpa_pkg::TopBlock;
      while (p + bpa_pkg::TopBlock < n) begin
         push_block(bpa_pkg::MaxOrder, p);
         p += bpa_pkg::TopBlock;
      end
      single_start = p;
      for (; p < n; p++) push_block(bpa_pkg::SingleList, p);
   endfunction

   function automatic void coalesce(int unsigned page, int unsigned order);
      int unsigned v, buddy;
      if (order > bpa_pkg::MaxOrder) order = bpa_pkg::MaxOrder;
      while (order < bpa_pkg::MaxOrder) begin
         v = 1 << order;
         buddy = ((page & (2 * v - 1)) == v) ? page - v : page + v;
         if (!unlink_block(order, buddy)) break;
         if (buddy < page) page = buddy;
         order++;
      end
      push_block(order, page);
   endfunction

   function automatic alloc_rsp_type predict_rsp(bpa_pkg::cmd_type cmd, logic [11:0] count,
                                                 logic [31:0] addr, logic [3:0] ford);
      alloc_rsp_type r = '0;
      int unsigned page;
      case (cmd)
         bpa_pkg::CMD_INIT: begin
            seed_lists();
            r.ok = 1'b1;
         end
         bpa_pkg::CMD_ALLOC: r = take_block(count);
         bpa_pkg::CMD_ALLOC_ONE: begin
            page = pop_head(bpa_pkg::SingleList);
            if (page != bpa_pkg::MaxPages) begin
               r.ok = 1'b1;
               r.addr = page_addr(page);
            end else begin
               r = take_block(1);
            end
         end
         default: begin
            page = (addr - base_reg) >> 12;
            if (page < managed_pages()) begin
               if (page < single_start) coalesce(page, ford);
               else push_block(bpa_pkg::SingleList, page);
               r.ok = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_item(bpa_pkg::cmd_type cmd, logic [11:0] count, logic [31:0] addr,
                            logic [3:0] ford);
      alloc_rsp_type r;
      if (!calm && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, ford, addr, count, cmd};
      do @(posedge clock); while (!req_tready);
      r = predict_rsp(cmd, count, addr, ford);
      pending_rsp.push_back(r);
      if (cmd == bpa_pkg::CMD_INIT) live_blocks.delete();
      else if (cmd != bpa_pkg::CMD_FREE && r.ok) live_blocks.push_back({r.addr, r.order});
   endtask

   task automatic finish_sending();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_reg(bpa_pkg::csr_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == bpa_pkg::CSR_BASE) base_reg = value;
      else total_reg = value[13:0];
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(bpa_pkg::CMD_ALLOC, 12'd1, '0, '0);         // empty lists before init
      send_item(bpa_pkg::CMD_INIT, '0, '0, '0);
      send_item(bpa_pkg::CMD_ALLOC, 12'd0, '0, '0);
      send_item(bpa_pkg::CMD_ALLOC, 12'hFFF, 32'hFFFF_FFFF, 4'hF);
      send_item(bpa_pkg::CMD_ALLOC, 12'd1025, '0, '0);
      send_item(bpa_pkg::CMD_ALLOC, 12'd1024, '0, '0);
      send_item(bpa_pkg::CMD_ALLOC, 12'd3, '0, '0);
      send_item(bpa_pkg::CMD_ALLOC, 12'd513, '0, '0);
      send_item(bpa_pkg::CMD_ALLOC, 12'd1, '0, '0);
      send_item(bpa_pkg::CMD_ALLOC_ONE, '0, '0, '0);
      send_item(bpa_pkg::CMD_FREE, '0, 32'h0000_2000, 4'd1);
      send_item(bpa_pkg::CMD_FREE, '0, 32'h0000_0FFF, 4'd0);
      send_item(bpa_pkg::CMD_FREE, '0, 32'h0000_1000, 4'hF);   // order clamped to the top
      send_item(bpa_pkg::CMD_FREE, '0, 32'hFFFF_FFFF, 4'd0);   // beyond the managed pages
      send_item(bpa_pkg::CMD_FREE, '0, 32'h01FF_F000, 4'd0);   // last page, buffer region
      send_item(bpa_pkg::CMD_FREE, '0, 32'h0000_3000, 4'd0);   // page inside the order-1 block at 0x2000
      send_item(bpa_pkg::CMD_ALLOC_ONE, '0, '0, '0);
      send_item(bpa_pkg::CMD_ALLOC, 12'd2, '0, '0);
      finish_sending();
   endtask

   task automatic random_item();
      int unsigned pick = $urandom_range(99);
      int unsigned o, idx;
      live_block_type b;
      if (pick < 3) begin
         send_item(bpa_pkg::CMD_INIT, 12'($urandom), $urandom, 4'($urandom));
      end else if (pick < 40) begin
         o = $urandom_range(bpa_pkg::MaxOrder);
         if ($urandom_range(9) == 0) begin
            send_item(bpa_pkg::CMD_ALLOC, 12'($urandom), $urandom, 4'($urandom));
         end else begin
            send_item(bpa_pkg::CMD_ALLOC, 12'($urandom_range(1 << o, (1 << o) / 2 + 1)),
                      $urandom, 4'($urandom));
         end
      end else if (pick < 55) begin
         send_item(bpa_pkg::CMD_ALLOC_ONE, 12'($urandom), $urandom, 4'($urandom));
      end else if (pick < 90 && live_blocks.size() > 0) begin
         idx = $urandom_range(live_blocks.size() - 1);
         b = live_blocks[idx];
         live_blocks.delete(idx);
         send_item(bpa_pkg::CMD_FREE, 12'($urandom), b.addr | $urandom_range(4095), b.order);
      end else begin
         send_item(bpa_pkg::CMD_FREE, 12'($urandom), $urandom_range(1) ? $urandom
                   : base_reg + ($urandom_range(bpa_pkg::MaxPages) << 12), 4'($urandom));
      end
   endtask

   task automatic test_random(int count);
      send_item(bpa_pkg::CMD_INIT, '0, '0, '0);
      for (int i = 0; i < count; i++) begin
         calm = (i < count / 4);
         random_item();
      end
      calm = 1'b0;
      finish_sending();
   endtask

   task automatic test_backpressure();
      send_item(bpa_pkg::CMD_INIT, '0, '0, '0);
      hold_request = 1'b1;
      for (int i = 0; i < 30; i++) random_item();
      hold_request = 1'b0;
      finish_sending();
   endtask

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request && hold_count == 0) begin
         hold_count <= 400;
         rsp_tready <= 1'b0;
      end else if (hold_count > 1) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (!hold_request) hold_count <= 0;
         rsp_tready <= calm || reset || ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin
      alloc_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[32:1], rsp_tdata[36:33]};
         if (pending_rsp.size() == 0) begin
            $error("unexpected result %h", got);
            fails++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.ok !== want.ok) begin
               $error("ok: expected %h, got %h", want.ok, got.ok);
               fails++;
            end
            if (got.addr !== want.addr) begin
               $error("block_address: expected %h, got %h", want.addr, got.addr);
               fails++;
            end
            if (got.order !== want.order) begin
               $error("block_order: expected %h, got %h", want.order, got.order);
               fails++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles > 1000000) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < bpa_pkg::NumLists; i++) heads[i] = 14'(bpa_pkg::MaxPages);
      single_start = 0;
      base_reg = '0;
      total_reg = 14'd8192;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(330);
      write_reg(bpa_pkg::CSR_BASE, 32'hFFFF_F000);
      write_reg(bpa_pkg::CSR_TOTAL, 32'd2048);
      test_random(230);
      test_backpressure();
      write_reg(bpa_pkg::CSR_BASE, {20'($urandom_range(32'hFFFFF)), 12'h000});
      write_reg(bpa_pkg::CSR_TOTAL, 32'd8192);
      test_random(230);
      write_reg(bpa_pkg::CSR_BASE, 32'h0);
      write_reg(bpa_pkg::CSR_TOTAL, $urandom_range(8192, 2048));
      test_random(200);
      if (fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== buddy_page_allocator_core.f =====
design/bpa_pkg.sv
design/bpa_link_ram.sv
design/buddy_page_allocator_core.sv
dv/tb_buddy_page_allocator_core.sv
